@@ design/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/insfd_pkg.sv @@
// Package for the INS frame deframer: sync codes, frame layout and field table.
// No dependencies; used by ins_frame_deframer_xor_core.
`timescale 1ns / 1ps
`default_nettype none

package insfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 63;
    localparam logic [5:0]  CHK_POS     = 6'(FRAME_BYTES - 1);
    localparam logic [5:0]  WEEK_POS    = 6'd58;
    localparam logic [7:0]  SYNC0       = 8'hBD;
    localparam logic [7:0]  SYNC1       = 8'hDB;
    localparam logic [7:0]  SYNC2       = 8'h0B;

    // Field ids with special handling
    localparam logic [4:0]  FID_TIME    = 5'd20;
    localparam logic [4:0]  FID_WEEK    = 5'd21;

    // How the raw bytes of a field are turned into a value
    typedef enum logic [2:0] {
        KIND_S16,
        KIND_YAW,
        KIND_S32,
        KIND_U32,
        KIND_NIB,
        KIND_U8
    } field_kind_t;

    typedef struct packed {
        logic [5:0]  pos;     // first byte in the frame
        logic [1:0]  last_b;  // byte count minus one
        field_kind_t kind;
    } field_desc_t;

    // Field table, indexed by field id
    function automatic field_desc_t field_desc(input logic [4:0] id);
        field_desc_t d;
        d = '{pos: 6'd3, last_b: 2'd1, kind: KIND_S16};
        case (id)
            5'd0:  d = '{pos: 6'd3,  last_b: 2'd1, kind: KIND_S16};
            5'd1:  d = '{pos: 6'd5,  last_b: 2'd1, kind: KIND_S16};
            5'd2:  d = '{pos: 6'd7,  last_b: 2'd1, kind: KIND_YAW};
            5'd3:  d = '{pos: 6'd9,  last_b: 2'd1, kind: KIND_S16};
            5'd4:  d = '{pos: 6'd11, last_b: 2'd1, kind: KIND_S16};
            5'd5:  d = '{pos: 6'd13, last_b: 2'd1, kind: KIND_S16};
            5'd6:  d = '{pos: 6'd15, last_b: 2'd1, kind: KIND_S16};
            5'd7:  d = '{pos: 6'd17, last_b: 2'd1, kind: KIND_S16};
            5'd8:  d = '{pos: 6'd19, last_b: 2'd1, kind: KIND_S16};
            5'd9:  d = '{pos: 6'd21, last_b: 2'd3, kind: KIND_S32};
            5'd10: d = '{pos: 6'd25, last_b: 2'd3, kind: KIND_S32};
            5'd11: d = '{pos: 6'd29, last_b: 2'd3, kind: KIND_S32};
            5'd12: d = '{pos: 6'd33, last_b: 2'd1, kind: KIND_S16};
            5'd13: d = '{pos: 6'd35, last_b: 2'd1, kind: KIND_S16};
            5'd14: d = '{pos: 6'd37, last_b: 2'd1, kind: KIND_S16};
            5'd15: d = '{pos: 6'd39, last_b: 2'd0, kind: KIND_NIB};
            5'd16: d = '{pos: 6'd56, last_b: 2'd0, kind: KIND_U8};
            5'd17: d = '{pos: 6'd46, last_b: 2'd1, kind: KIND_S16};
            5'd18: d = '{pos: 6'd48, last_b: 2'd1, kind: KIND_S16};
            5'd19: d = '{pos: 6'd50, last_b: 2'd1, kind: KIND_S16};
            5'd20: d = '{pos: 6'd52, last_b: 2'd3, kind: KIND_U32};
            5'd21: d = '{pos: 6'd58, last_b: 2'd3, kind: KIND_U32};
            default: d = '{pos: 6'd3, last_b: 2'd1, kind: KIND_S16};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ design/ins_frame_deframer_xor_core.sv @@
// INS frame deframer: sync hunt, XOR check, frame memory and field unpacker.
// Depends on insfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel: one received byte per request on rx_byte (in_valid/in_stall).
//   Output channel: one decoded field per request (field_id, field_value,
//   last_field) on out_valid/out_stall.
//   Bytes are taken at one per cycle while hunting for BD DB 0B and while the
//   63-byte frame is written into a 64 x 8 synchronous RAM.
//   When the checksum byte matches, in_stall rises and a sequencer reads the
//   frame back through the single RAM read port, one byte per cycle within a
//   field. After its bytes, each field waits out the read latency, then the
//   emit slot; a burst holds 21 or 22 fields, paced by that read port.
//   A bad frame is dropped without output and the next byte is taken at once.
//   When the receiver stalls, the current field is held in the output register
//   and the sequencer waits; input stays stalled until the last field is loaded.
//   Reset (rst_n low, asynchronous) returns to the hunt for the first sync byte
//   and empties the output register. RAM contents are not cleared: every byte
//   read back was written earlier in the same frame.

`include "assert_macros.svh"

module ins_frame_deframer_xor_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [4:0]          field_id,
    output logic signed [32:0]  field_value,
    output logic                last_field
);
    import insfd_pkg::*;

    typedef enum logic [1:0] {
        HUNT_SYNC0,
        HUNT_SYNC1,
        HUNT_SYNC2,
        HUNT_BODY
    } hunt_t;

    typedef enum logic [1:0] {
        ST_RX,
        ST_READ,
        ST_WAIT,
        ST_EMIT
    } state_t;

    // Frame memory
    logic [7:0] frame_mem [64];

    state_t      state_reg;
    hunt_t       hunt_reg, hunt_next;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  wx_reg, wx_next;
    logic        week_ok_reg;
    logic [4:0]  fld_reg;
    logic [1:0]  bsel_reg;
    logic        rd_pend_reg;
    logic [1:0]  rd_bsel_reg;
    logic [7:0]  rd_data_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;
    logic [4:0]  field_id_reg;
    logic [32:0] field_value_reg;
    logic        last_field_reg;

    logic        in_acc;
    logic        start;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic        frame_good;
    logic        rd_en;
    logic [5:0]  rd_addr;
    logic        slot_free;
    logic        last_now;
    logic [32:0] value;
    field_desc_t fdesc;

    assign in_stall  = (state_reg != ST_RX);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // Receive path: sync hunt, running checksum, week checksum, memory write
    always_comb
    begin
        hunt_next  = hunt_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        wx_next    = wx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        frame_good = 1'b0;
        start      = 1'b0;
        if (in_acc)
        begin
            case (hunt_reg)
                HUNT_SYNC0:
                begin
                    start = 1'b1;
                end
                HUNT_SYNC1, HUNT_SYNC2:
                begin
                    if (rx_byte == ((hunt_reg == HUNT_SYNC1) ? SYNC1 : SYNC2))
                    begin
                        wr_en     = 1'b1;
                        xor_next  = xor_reg ^ rx_byte;
                        idx_next  = idx_reg + 6'd1;
                        hunt_next = (hunt_reg == HUNT_SYNC1) ? HUNT_SYNC2 : HUNT_BODY;
                    end
                    else
                    begin
                        start = 1'b1;
                    end
                end
                default:
                begin
                    wr_en = 1'b1;
                    if (idx_reg >= CHK_POS)
                    begin
                        frame_good = (rx_byte == xor_reg);
                        hunt_next  = HUNT_SYNC0;
                        idx_next   = 6'd0;
                        xor_next   = 8'd0;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        idx_next = idx_reg + 6'd1;
                        if (idx_reg == WEEK_POS)
                        begin
                            wx_next = rx_byte;
                        end
                        else if (idx_reg inside {[WEEK_POS + 6'd1 : CHK_POS - 6'd1]})
                        begin
                            wx_next = wx_reg ^ rx_byte;
                        end
                    end
                end
            endcase
        end
        // Restart the hunt, reusing this byte as a possible first sync byte
        if (start)
        begin
            if (rx_byte == SYNC0)
            begin
                wr_en     = 1'b1;
                wr_addr   = 6'd0;
                xor_next  = rx_byte;
                idx_next  = 6'd1;
                hunt_next = HUNT_SYNC1;
            end
            else
            begin
                xor_next  = 8'd0;
                idx_next  = 6'd0;
                hunt_next = HUNT_SYNC0;
            end
        end
    end

    // Read-back address and field formatting
    assign fdesc   = field_desc(fld_reg);
    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = fdesc.pos + {4'd0, bsel_reg};
    assign last_now = (fld_reg == FID_WEEK) || ((fld_reg == FID_TIME) && !week_ok_reg);

    always_comb
    begin
        case (fdesc.kind)
            KIND_S16: value = {{17{acc_reg[15]}}, acc_reg[15:0]};
            KIND_YAW: value = {18'd0, acc_reg[14:0]};
            KIND_S32: value = {acc_reg[31], acc_reg};
            KIND_U32: value = {1'b0, acc_reg};
            KIND_NIB: value = {29'd0, acc_reg[3:0]};
            KIND_U8:  value = {25'd0, acc_reg[7:0]};
            default:  value = {1'b0, acc_reg};
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // Assemble field bytes as they return from memory
    always_ff @(posedge clk)
    begin
        rd_bsel_reg <= bsel_reg;
        if (rd_pend_reg)
        begin
            acc_reg[rd_bsel_reg * 8 +: 8] <= rd_data_reg;
        end
    end

    // State, receive registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RX;
            hunt_reg        <= HUNT_SYNC0;
            idx_reg         <= 6'd0;
            xor_reg         <= 8'd0;
            wx_reg          <= 8'd0;
            week_ok_reg     <= 1'b0;
            fld_reg         <= 5'd0;
            bsel_reg        <= 2'd0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            field_id_reg    <= 5'd0;
            field_value_reg <= 33'd0;
            last_field_reg  <= 1'b0;
        end
        else
        begin
            hunt_reg    <= hunt_next;
            idx_reg     <= idx_next;
            xor_reg     <= xor_next;
            wx_reg      <= wx_next;
            rd_pend_reg <= rd_en;
            // Load a new field, or drop the one the receiver has taken
            if ((state_reg == ST_EMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_RX:
                begin
                    if (frame_good)
                    begin
                        state_reg   <= ST_READ;
                        fld_reg     <= 5'd0;
                        bsel_reg    <= 2'd0;
                        week_ok_reg <= (wx_reg == rx_byte);
                    end
                end
                ST_READ:
                begin
                    if (bsel_reg == fdesc.last_b)
                    begin
                        bsel_reg  <= 2'd0;
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        bsel_reg <= bsel_reg + 2'd1;
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        field_id_reg    <= fld_reg;
                        field_value_reg <= value;
                        last_field_reg  <= last_now;
                        if (last_now)
                        begin
                            state_reg <= ST_RX;
                        end
                        else
                        begin
                            fld_reg   <= fld_reg + 5'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RX;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_id    = field_id_reg;
    assign field_value = field_value_reg;
    assign last_field  = last_field_reg;

    // Checks
    `ASSERT_CLK(a_hunt_idle_clean,
        (hunt_reg != HUNT_SYNC0) || ((idx_reg == 6'd0) && (xor_reg == 8'd0)),
        "hunt idle with stale index or checksum")
    `ASSERT_CLK(a_fld_range, (state_reg == ST_RX) || (fld_reg <= FID_WEEK),
        "field index past the last field")
    `ASSERT_CLK(a_rd_byte_range, !rd_pend_reg || (rd_bsel_reg <= fdesc.last_b),
        "read byte beyond field length")
    `ASSERT_NEXT(a_last_returns, (state_reg == ST_EMIT) && slot_free && last_now,
        (state_reg == ST_RX) && out_valid && last_field,
        "last field did not end the burst")

endmodule

`default_nettype wire
